// ===== sv/sfcd_pkg.sv =====
`timescale 1ns / 1ps

package sfcd_pkg;

	localparam int LINE_LENGTH = 32;
	localparam int ADDR_W = $clog2(LINE_LENGTH);
	localparam int CNT_W = $clog2(LINE_LENGTH + 1);
	localparam int IDX_W = 4;
	localparam int PACKET_BYTES = 14;
	localparam int CHANNELS = 8;

	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE = 8'h7D;
	localparam logic [7:0] ESC_MASK = 8'h20;
	localparam logic [7:0] HEADER_BYTE = 8'h80;
	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PACKET_BYTES - 1);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_START = 2'd1,
		PH_FRAME = 2'd2,
		PH_ESCAPE = 2'd3
	} rx_phase_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_SCAN = 2'd1,
		ST_WAIT = 2'd2,
		ST_EMIT = 2'd3
	} seq_state_t;

	typedef struct packed {
		logic valid;
		logic [IDX_W-1:0] idx;
		logic [7:0] data;
	} rd_beat_t;

	typedef struct packed {
		logic done;
		logic ok;
	} chk_res_t;

	typedef logic [CHANNELS-1:0][11:0] chan_vec_t;

endpackage

// ===== sv/sfcd_byte_if.sv =====
`timescale 1ns / 1ps

interface sfcd_byte_if;
	logic valid;
	logic ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== sv/sfcd_chan_if.sv =====
`timescale 1ns / 1ps

interface sfcd_chan_if;
	logic valid;
	logic ready;
	logic [11:0] channel_0;
	logic [11:0] channel_1;
	logic [11:0] channel_2;
	logic [11:0] channel_3;
	logic [11:0] channel_4;
	logic [11:0] channel_5;
	logic [11:0] channel_6;
	logic [11:0] channel_7;

	modport source (output valid, output channel_0, output channel_1, output channel_2,
		output channel_3, output channel_4, output channel_5, output channel_6,
		output channel_7, input ready);
	modport sink (input valid, input channel_0, input channel_1, input channel_2,
		input channel_3, input channel_4, input channel_5, input channel_6,
		input channel_7, output ready);
endinterface

// ===== sv/sfcd_ram.sv =====
`timescale 1ns / 1ps

module sfcd_ram #(
	parameter int DEPTH = 32,
	parameter int AW = 5,
	parameter int DW = 8
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [DW-1:0] wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/sfcd_chk.sv =====
`timescale 1ns / 1ps

// Consumes the 14 stored bytes in address order: running XOR, header test,
// and a copy of the payload bytes for unpacking.
module sfcd_chk (
	input logic clk,
	input logic arst_n,
	input sfcd_pkg::rd_beat_t beat,
	output sfcd_pkg::chk_res_t res,
	output sfcd_pkg::chan_vec_t chans
);

	logic [7:0] byte_q [1:12];
	logic [7:0] sum_q;
	logic hdr_q;
	logic done_q;
	logic ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			ok_q <= 1'b0;
		end else begin
			done_q <= beat.valid && (beat.idx == sfcd_pkg::LAST_IDX);
			if (beat.valid && (beat.idx == sfcd_pkg::LAST_IDX)) begin
				ok_q <= hdr_q && (sum_q == beat.data);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (beat.valid) begin
			if (beat.idx == '0) begin
				sum_q <= beat.data;
				hdr_q <= (beat.data == sfcd_pkg::HEADER_BYTE);
			end else if (beat.idx < sfcd_pkg::LAST_IDX) begin
				sum_q <= sum_q ^ beat.data;
				byte_q[beat.idx] <= beat.data;
			end
		end
	end

	assign res.done = done_q;
	assign res.ok = ok_q;

	// groups of three bytes give two 12-bit channels
	always_comb begin
		for (int g = 0; g < 4; g++) begin
			chans[2*g] = {byte_q[3*g+2][7:4], byte_q[3*g+1]};
			chans[2*g+1] = {byte_q[3*g+3][3:0], byte_q[3*g+2][3:0], byte_q[3*g+3][7:4]};
		end
	end

endmodule

// ===== sv/stuffed_frame_channel_decoder_unit.sv =====
`timescale 1ns / 1ps

// Byte deframer with XOR check and 8x12-bit channel unpack.
// Throughput: one byte per cycle while fewer than 14 bytes are held; a byte that
// leaves 14 or more held starts a walk of the frame store through its single read
// port, and ready stays low until the check fails or the channels load the output register.
// Result path: store walk, registered store read, checker, verdict, then output register, held back by output stall.
// Reset: receiver idle, byte count zero; frame store contents are not cleared.
module stuffed_frame_channel_decoder_unit (
	input logic clk,
	input logic arst_n,
	sfcd_byte_if.sink rx,
	sfcd_chan_if.source chan
);

	sfcd_pkg::seq_state_t state_q, state_d;
	sfcd_pkg::rx_phase_t phase_q, phase_d;
	logic [sfcd_pkg::CNT_W-1:0] count_q, count_d;
	logic [sfcd_pkg::IDX_W-1:0] idx_q, idx_d;

	logic accept;
	logic store_req;
	logic [7:0] store_val;
	logic we;
	logic re;
	logic [sfcd_pkg::ADDR_W-1:0] raddr;
	logic [7:0] rdata;
	logic rd_v_s1;
	logic [sfcd_pkg::IDX_W-1:0] rd_idx_s1;
	sfcd_pkg::rd_beat_t beat;
	sfcd_pkg::chk_res_t res;
	sfcd_pkg::chan_vec_t chans;
	sfcd_pkg::chan_vec_t out_q;
	logic out_valid_q;
	logic out_load;

	assign accept = rx.valid && rx.ready;

	// receiver phase and store index
	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		store_req = 1'b0;
		store_val = rx.rx_byte;
		unique case (phase_q)
			sfcd_pkg::PH_IDLE: begin
				if (rx.rx_byte == sfcd_pkg::FLAG_BYTE) begin
					count_d = '0;
					phase_d = sfcd_pkg::PH_START;
				end else begin
					store_req = 1'b1;
				end
			end
			sfcd_pkg::PH_START: begin
				if (rx.rx_byte == sfcd_pkg::FLAG_BYTE) begin
					count_d = '0;
					phase_d = sfcd_pkg::PH_FRAME;
				end else begin
					store_req = 1'b1;
				end
			end
			sfcd_pkg::PH_FRAME: begin
				if (rx.rx_byte == sfcd_pkg::ESC_BYTE) begin
					phase_d = sfcd_pkg::PH_ESCAPE;
				end else if (rx.rx_byte == sfcd_pkg::FLAG_BYTE) begin
					count_d = '0;
				end else begin
					store_req = 1'b1;
				end
			end
			sfcd_pkg::PH_ESCAPE: begin
				store_val = rx.rx_byte ^ sfcd_pkg::ESC_MASK;
				store_req = 1'b1;
				phase_d = sfcd_pkg::PH_FRAME;
			end
			default: begin
				phase_d = sfcd_pkg::PH_IDLE;
			end
		endcase
		we = accept && store_req && (count_q < sfcd_pkg::CNT_W'(sfcd_pkg::LINE_LENGTH));
		if (we) begin
			count_d = (store_val == sfcd_pkg::NEWLINE_BYTE) ? '0 : count_q + 1'b1;
		end
		if (count_d >= sfcd_pkg::CNT_W'(sfcd_pkg::PACKET_BYTES)) begin
			phase_d = sfcd_pkg::PH_IDLE;
		end
	end

	// sequencer: accept, walk bytes 0..13, wait for verdict, emit on a match
	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		rx.ready = 1'b0;
		re = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			sfcd_pkg::ST_IDLE: begin
				rx.ready = 1'b1;
				if (accept && (count_d >= sfcd_pkg::CNT_W'(sfcd_pkg::PACKET_BYTES))) begin
					state_d = sfcd_pkg::ST_SCAN;
					idx_d = '0;
				end
			end
			sfcd_pkg::ST_SCAN: begin
				re = 1'b1;
				idx_d = idx_q + 1'b1;
				if (idx_q == sfcd_pkg::LAST_IDX) begin
					state_d = sfcd_pkg::ST_WAIT;
				end
			end
			sfcd_pkg::ST_WAIT: begin
				if (res.done) begin
					state_d = res.ok ? sfcd_pkg::ST_EMIT : sfcd_pkg::ST_IDLE;
				end
			end
			sfcd_pkg::ST_EMIT: begin
				if (!out_valid_q || chan.ready) begin
					out_load = 1'b1;
					state_d = sfcd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sfcd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfcd_pkg::ST_IDLE;
			phase_q <= sfcd_pkg::PH_IDLE;
			count_q <= '0;
			idx_q <= '0;
			rd_v_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			if (accept) begin
				phase_q <= phase_d;
				count_q <= count_d;
			end
			rd_v_s1 <= re;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (chan.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
		if (out_load) begin
			out_q <= chans;
		end
	end

	assign raddr = sfcd_pkg::ADDR_W'(idx_q);

	sfcd_ram #(
		.DEPTH(sfcd_pkg::LINE_LENGTH),
		.AW(sfcd_pkg::ADDR_W),
		.DW(8)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(count_q[sfcd_pkg::ADDR_W-1:0]),
		.wdata(store_val),
		.re(re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign beat.valid = rd_v_s1;
	assign beat.idx = rd_idx_s1;
	assign beat.data = rdata;

	sfcd_chk u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.beat(beat),
		.res(res),
		.chans(chans)
	);

	assign chan.valid = out_valid_q;
	assign chan.channel_0 = out_q[0];
	assign chan.channel_1 = out_q[1];
	assign chan.channel_2 = out_q[2];
	assign chan.channel_3 = out_q[3];
	assign chan.channel_4 = out_q[4];
	assign chan.channel_5 = out_q[5];
	assign chan.channel_6 = out_q[6];
	assign chan.channel_7 = out_q[7];

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import sfcd_pkg::*;

	typedef logic [7:0] frame_bytes_t [PACKET_BYTES];

	// Tracks the deframer state per accepted byte and holds the channel sets still owed.
	class frame_decode_tracker;
		rx_phase_t phase;
		logic [5:0] held;
		logic [7:0] line_buf [LINE_LENGTH];
		chan_vec_t pending [$];
		int errors;

		function new();
			phase = PH_IDLE;
			held = '0;
			errors = 0;
		endfunction

		function void hold_byte(logic [7:0] b);
			if (held < LINE_LENGTH) begin
				line_buf[held] = b;
				held = (b == NEWLINE_BYTE) ? 6'd0 : held + 6'd1;
			end
		endfunction

		function void take_byte(logic [7:0] b);
			logic [7:0] sum;
			chan_vec_t v;
			int k;
			case (phase)
				PH_IDLE: begin
					if (b == FLAG_BYTE) begin
						held = '0;
						phase = PH_START;
					end else begin
						hold_byte(b);
					end
				end
				PH_START: begin
					if (b == FLAG_BYTE) begin
						held = '0;
						phase = PH_FRAME;
					end else begin
						hold_byte(b);
					end
				end
				PH_FRAME: begin
					if (b == ESC_BYTE) begin
						phase = PH_ESCAPE;
					end else if (b == FLAG_BYTE) begin
						held = '0;
					end else begin
						hold_byte(b);
					end
				end
				PH_ESCAPE: begin
					hold_byte(b ^ ESC_MASK);
					phase = PH_FRAME;
				end
			endcase
			// check repeats on every byte while 14+ are held
			if (held >= PACKET_BYTES) begin
				sum = '0;
				for (int i = 0; i < PACKET_BYTES - 1; i++)
					sum ^= line_buf[i];
				if (sum == line_buf[PACKET_BYTES-1] && line_buf[0] == HEADER_BYTE) begin
					for (int c = 0; c < CHANNELS / 2; c++) begin
						k = 1 + 3 * c;
						v[2*c] = {line_buf[k+1][7:4], line_buf[k]};
						v[2*c+1] = {line_buf[k+2][3:0], line_buf[k+1][3:0],
							line_buf[k+2][7:4]};
					end
					pending.push_back(v);
				end
				phase = PH_IDLE;
			end
		endfunction

		function void check_channels(chan_vec_t got);
			chan_vec_t want;
			if (pending.size() == 0) begin
				$error("channel transaction with no decoded frame pending");
				errors++;
			end else begin
				want = pending.pop_front();
				for (int c = 0; c < CHANNELS; c++) begin
					if (got[c] !== want[c]) begin
						$error("channel_%0d: expected 0x%03h, got 0x%03h", c, want[c], got[c]);
						errors++;
					end
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	sfcd_byte_if rx_if();
	sfcd_chan_if chan_if();

	stuffed_frame_channel_decoder_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_if),
		.chan(chan_if)
	);

	frame_decode_tracker tracker = new();
	logic [7:0] tx_queue [$];
	int bytes_sent = 0;
	int src_idle_pct = 0;
	int snk_stall_pct = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [7:0] frame_xor(frame_bytes_t body);
		logic [7:0] s;
		s = '0;
		for (int i = 0; i < PACKET_BYTES - 1; i++)
			s ^= body[i];
		return s;
	endfunction

	// flagged: two flags then byte-stuffed body; otherwise a newline clears the count first
	function automatic void push_frame(frame_bytes_t body, bit flagged);
		if (flagged) begin
			tx_queue.push_back(FLAG_BYTE);
			tx_queue.push_back(FLAG_BYTE);
		end else begin
			tx_queue.push_back(NEWLINE_BYTE);
		end
		foreach (body[i]) begin
			if (flagged && (body[i] == FLAG_BYTE || body[i] == ESC_BYTE
					|| $urandom_range(15) == 0)) begin
				tx_queue.push_back(ESC_BYTE);
				tx_queue.push_back(body[i] ^ ESC_MASK);
			end else begin
				tx_queue.push_back(body[i]);
			end
		end
	endfunction

	function automatic void fill_body(output frame_bytes_t body, input bit good_hdr,
			input bit good_sum);
		body[0] = good_hdr ? HEADER_BYTE : 8'($urandom_range(255));
		for (int i = 1; i < PACKET_BYTES - 1; i++) begin
			case ($urandom_range(9))
				0: body[i] = FLAG_BYTE;
				1: body[i] = ESC_BYTE;
				2: body[i] = $urandom_range(1) ? 8'hFF : 8'h00;
				default: body[i] = 8'($urandom_range(255));
			endcase
		end
		body[PACKET_BYTES-1] = frame_xor(body) ^ (good_sum ? 8'h00 : 8'($urandom_range(1, 255)));
	endfunction

	function automatic void push_noise(int n);
		for (int i = 0; i < n; i++)
			tx_queue.push_back(8'($urandom_range(255)));
	endfunction

	function automatic void plan_sequence();
		frame_bytes_t body;
		int r;
		r = $urandom_range(99);
		if (r < 60) begin
			fill_body(body, 1'b1, 1'b1);
			push_frame(body, 1'b1);
			// trailing bytes re-trigger the check and can fill the line store
			if ($urandom_range(9) < 3)
				push_noise($urandom_range(1, 22));
		end else if (r < 70) begin
			fill_body(body, 1'b1, 1'b1);
			push_frame(body, 1'b0);
		end else if (r < 80) begin
			fill_body(body, $urandom_range(1), 1'b0);
			if ($urandom_range(1))
				body[PACKET_BYTES-1] = frame_xor(body);
			push_frame(body, $urandom_range(3) != 0);
		end else if (r < 88) begin
			tx_queue.push_back(FLAG_BYTE);
			tx_queue.push_back(FLAG_BYTE);
			push_noise($urandom_range(1, 13));
		end else begin
			push_noise($urandom_range(1, 40));
		end
	endfunction

	task automatic send_byte(input logic [7:0] b);
		if ($urandom_range(99) < src_idle_pct) begin
			rx_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.rx_byte <= b;
		@(posedge clk);
		while (!rx_if.ready)
			@(posedge clk);
		tracker.take_byte(b);
		bytes_sent++;
	endtask

	task automatic drain_queue();
		while (tx_queue.size() != 0)
			send_byte(tx_queue.pop_front());
	endtask

	always @(posedge clk) begin
		if (chan_if.valid && chan_if.ready)
			tracker.check_channels({chan_if.channel_7, chan_if.channel_6, chan_if.channel_5,
				chan_if.channel_4, chan_if.channel_3, chan_if.channel_2, chan_if.channel_1,
				chan_if.channel_0});
		chan_if.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	initial begin
		frame_bytes_t body;
		arst_n <= 1'b0;
		rx_if.valid <= 1'b0;
		rx_if.rx_byte <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stuffed frame with channel extremes, flag and escape inside the payload
		body = '{HEADER_BYTE, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
			FLAG_BYTE, ESC_BYTE, 8'h5E, 8'h5D, 8'hA5, 8'h3C, 8'h00};
		body[PACKET_BYTES-1] = frame_xor(body);
		push_frame(body, 1'b1);
		tx_queue.push_back(8'h33);          // repeated check, same channels again
		tx_queue.push_back(NEWLINE_BYTE);   // clears the byte count
		tx_queue.push_back(FLAG_BYTE);
		tx_queue.push_back(FLAG_BYTE);
		tx_queue.push_back(8'h11);
		tx_queue.push_back(FLAG_BYTE);      // flag inside a frame restarts it
		drain_queue();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin src_idle_pct = 0; snk_stall_pct = 0; end
				1: begin src_idle_pct = 81; snk_stall_pct = 0; end
				2: begin src_idle_pct = 0; snk_stall_pct = 81; end
				default: begin src_idle_pct = 29; snk_stall_pct = 29; end
			endcase
			while (bytes_sent < 25 + (p + 1) * 345) begin
				plan_sequence();
				drain_queue();
			end
		end
		rx_if.valid <= 1'b0;

		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (tracker.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
